// File: sv/wrp_pkg.sv
// package for the wav riff header parser
// parse phases, chunk tags, command and status codes; no dependencies
`default_nettype none

package wrp_pkg;

    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_phase PH_RIFF = 3'd0;
    localparam t_phase PH_CHDR = 3'd1;
    localparam t_phase PH_FMT  = 3'd2;
    localparam t_phase PH_SKIP = 3'd3;
    localparam t_phase PH_PAD  = 3'd4;

    localparam t_cmd CMD_BYTE    = 2'd0;
    localparam t_cmd CMD_EOF     = 2'd1;
    localparam t_cmd CMD_RESTART = 2'd2;

    localparam t_status ST_PARSING = 2'd0;
    localparam t_status ST_OK      = 2'd1;
    localparam t_status ST_FAIL    = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [4:0]  RIFF_TAG_BYTES  = 5'd4;
    localparam logic [4:0]  RIFF_HDR_BYTES  = 5'd12;
    localparam logic [4:0]  CHUNK_HDR_BYTES = 5'd8;
    localparam logic [4:0]  FMT_BODY_BYTES  = 5'd16;
    localparam logic [31:0] FMT_BODY_SIZE   = 32'd16;

endpackage

`default_nettype wire

// File: sv/wav_riff_header_parser.sv
// wav riff header parser, top level
// byte-serial riff/wave header check and fmt chunk capture; uses wrp_pkg
// Takes one word per cycle while the output is not stalled (a file byte, an
// end-of-file mark or a restart) and returns exactly one status word per input
// word, registered in the result register from the input register. Every word
// is handled by a single pass through the parse logic between the input
// register and the state/result registers, so the block sustains one word per
// clock while the output is not stalled; the output register holds a stalled
// result while the input register keeps one more word waiting. Status stays
// at success or failure until a restart word, which also clears the format fields and format_valid.
`default_nettype none

module wav_riff_header_parser (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire wrp_pkg::t_cmd     i_command,
    input  wire  [7:0]             i_byte_value,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output wrp_pkg::t_status       o_status,
    output logic [15:0]            o_format_code,
    output logic [15:0]            o_channel_count,
    output logic [31:0]            o_samp_freq,
    output logic [31:0]            o_data_rate,
    output logic [15:0]            o_frame_size,
    output logic [15:0]            o_samp_depth,
    output logic                   o_format_valid
);
    import wrp_pkg::*;

    // input register
    logic        r_in_valid;
    t_cmd        r_command;
    logic [7:0]  r_byte;

    // parse state, also the result register
    logic        r_out_valid;
    t_phase      r_phase,      n_phase;
    logic [4:0]  r_count,      n_count;
    logic [63:0] r_shift,      n_shift;
    logic [127:0] r_fmt_body,  n_fmt_body;
    logic [31:0] r_skip,       n_skip;
    logic        r_pad,        n_pad;
    logic        r_fmt_seen,   n_fmt_seen;
    t_status     r_outcome,    n_outcome;
    logic [15:0] r_format_code, n_format_code;
    logic [15:0] r_channels,    n_channels;
    logic [31:0] r_samp_freq,   n_samp_freq;
    logic [31:0] r_data_rate,   n_data_rate;
    logic [15:0] r_frame_size,  n_frame_size;
    logic [15:0] r_bits,        n_bits;

    logic        advance;
    logic        work;

    assign advance    = !r_out_valid || !i_out_stall;
    assign work       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_comb begin
        logic [31:0] size;
        logic [31:0] id;
        logic [31:0] left;
        logic        odd;
        logic        go_skip;
        size    = '0;
        id      = '0;
        left    = '0;
        odd     = 1'b0;
        go_skip = 1'b0;

        n_phase       = r_phase;
        n_count       = r_count;
        n_shift       = r_shift;
        n_fmt_body    = r_fmt_body;
        n_skip        = r_skip;
        n_pad         = r_pad;
        n_fmt_seen    = r_fmt_seen;
        n_outcome     = r_outcome;
        n_format_code = r_format_code;
        n_channels    = r_channels;
        n_samp_freq   = r_samp_freq;
        n_data_rate   = r_data_rate;
        n_frame_size  = r_frame_size;
        n_bits        = r_bits;

        if (r_command == CMD_RESTART) begin
            n_phase       = PH_RIFF;
            n_count       = '0;
            n_shift       = '0;
            n_fmt_body    = '0;
            n_skip        = '0;
            n_pad         = 1'b0;
            n_fmt_seen    = 1'b0;
            n_outcome     = ST_PARSING;
            n_format_code = '0;
            n_channels    = '0;
            n_samp_freq   = '0;
            n_data_rate   = '0;
            n_frame_size  = '0;
            n_bits        = '0;
        end else if (r_outcome == ST_PARSING && r_command == CMD_EOF) begin
            if (r_phase == PH_RIFF || r_phase == PH_FMT || !r_fmt_seen) begin
                n_outcome = ST_FAIL;
            end else begin
                n_outcome = ST_OK;
            end
        end else if (r_outcome == ST_PARSING && r_command == CMD_BYTE) begin
            unique case (r_phase)
                PH_RIFF: begin
                    n_shift = {r_byte, r_shift[63:8]};
                    n_count = r_count + 5'd1;
                    if (n_count == RIFF_TAG_BYTES) begin
                        if (n_shift[63:32] != TAG_RIFF) n_outcome = ST_FAIL;
                    end else if (n_count >= RIFF_HDR_BYTES) begin
                        if (n_shift[63:32] != TAG_WAVE) begin
                            n_outcome = ST_FAIL;
                        end else begin
                            n_phase = PH_CHDR;
                            n_count = '0;
                            n_shift = '0;
                        end
                    end
                end
                PH_CHDR: begin
                    n_shift = {r_byte, r_shift[63:8]};
                    n_count = r_count + 5'd1;
                    if (n_count >= CHUNK_HDR_BYTES) begin
                        id      = n_shift[31:0];
                        size    = n_shift[63:32];
                        n_count = '0;
                        if (id == TAG_FMT) begin
                            if (size < FMT_BODY_SIZE) begin
                                n_outcome = ST_FAIL;
                            end else begin
                                n_skip     = size - FMT_BODY_SIZE;
                                n_pad      = size[0];
                                n_fmt_body = '0;
                                n_phase    = PH_FMT;
                            end
                        end else if (id == TAG_DATA && r_fmt_seen) begin
                            n_outcome = ST_OK;
                        end else begin
                            go_skip = 1'b1;
                            left    = size;
                            odd     = size[0];
                        end
                    end
                end
                PH_FMT: begin
                    n_fmt_body[{r_count[3:0], 3'b000} +: 8] = r_byte;
                    n_count = r_count + 5'd1;
                    if (n_count >= FMT_BODY_BYTES) begin
                        n_format_code = n_fmt_body[15:0];
                        n_channels    = n_fmt_body[31:16];
                        n_samp_freq   = n_fmt_body[63:32];
                        n_data_rate   = n_fmt_body[95:64];
                        n_frame_size  = n_fmt_body[111:96];
                        n_bits        = n_fmt_body[127:112];
                        n_fmt_seen    = 1'b1;
                        go_skip       = 1'b1;
                        left          = r_skip;
                        odd           = r_pad;
                    end
                end
                PH_SKIP: begin
                    if (r_skip != '0) n_skip = r_skip - 32'd1;
                    if (n_skip == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_CHDR;
                        n_count = '0;
                    end
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_CHDR;
                    n_count = '0;
                end
                default: begin
                    n_phase = PH_CHDR;
                    n_count = '0;
                end
            endcase

            // rest of the chunk, then the pad byte after an odd size
            if (go_skip) begin
                n_pad   = odd;
                n_skip  = left;
                n_count = '0;
                if (left != '0) begin
                    n_phase = PH_SKIP;
                end else if (odd) begin
                    n_phase = PH_PAD;
                end else begin
                    n_phase = PH_CHDR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_RIFF;
            r_count       <= '0;
            r_shift       <= '0;
            r_fmt_body    <= '0;
            r_skip        <= '0;
            r_pad         <= 1'b0;
            r_fmt_seen    <= 1'b0;
            r_outcome     <= ST_PARSING;
            r_format_code <= '0;
            r_channels    <= '0;
            r_samp_freq   <= '0;
            r_data_rate   <= '0;
            r_frame_size  <= '0;
            r_bits        <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (work) begin
                r_phase       <= n_phase;
                r_count       <= n_count;
                r_shift       <= n_shift;
                r_fmt_body    <= n_fmt_body;
                r_skip        <= n_skip;
                r_pad         <= n_pad;
                r_fmt_seen    <= n_fmt_seen;
                r_outcome     <= n_outcome;
                r_format_code <= n_format_code;
                r_channels    <= n_channels;
                r_samp_freq   <= n_samp_freq;
                r_data_rate   <= n_data_rate;
                r_frame_size  <= n_frame_size;
                r_bits        <= n_bits;
            end
        end
    end

    // input payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_command <= i_command;
            r_byte    <= i_byte_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_outcome;
    assign o_format_code   = r_format_code;
    assign o_channel_count = r_channels;
    assign o_samp_freq     = r_samp_freq;
    assign o_data_rate     = r_data_rate;
    assign o_frame_size    = r_frame_size;
    assign o_samp_depth    = r_bits;
    assign o_format_valid  = r_fmt_seen;

endmodule

`default_nettype wire
